// ===== hdl/pdh_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, word types and control structs of the point density histogram.
package pdh_pkg;

    // Grid and count geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COUNT_BITS  = 32;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

    // Fixed field and register widths
    localparam int SIZE_BITS     = 9;
    localparam int STRIDE_BITS   = 16;
    localparam int COORD_BITS    = 32;
    localparam int GAIN_BITS     = 32;
    localparam int FRAC_BITS     = 24;
    localparam int PROD_BITS     = COORD_BITS + GAIN_BITS;
    localparam int PIX_BITS      = PROD_BITS - FRAC_BITS;
    localparam int INDEX_BITS    = 16;
    localparam int STAT_BITS     = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;
    localparam logic [STAT_BITS-1:0]  STAT_LIMIT  = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_X_ORIGIN_RAW  = 3'd2,
        REG_Y_ORIGIN_RAW  = 3'd3,
        REG_X_GAIN        = 3'd4,
        REG_Y_GAIN        = 3'd5,
        REG_SAMPLE_STRIDE = 3'd6
    } cfg_reg_t;

    // Request codes
    typedef enum logic [1:0] {
        REQ_POINT = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FRAME = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic signed [COORD_BITS-1:0]  raw_x;
        logic signed [COORD_BITS-1:0]  raw_y;
        logic [INDEX_BITS-1:0]         pixel_index;
    } req_word_t;

    typedef struct packed {
        logic                   hit;
        logic [INDEX_BITS-1:0]  hit_index;
        logic [STAT_BITS-1:0]   density;
        logic [STAT_BITS-1:0]   max_density;
        logic [STAT_BITS-1:0]   points_read;
    } res_word_t;

    // Mapping setup, clamped sizes
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  x_origin;
        logic signed [COORD_BITS-1:0]  y_origin;
        logic [GAIN_BITS-1:0]          x_gain;
        logic [GAIN_BITS-1:0]          y_gain;
        logic [SIZE_BITS-1:0]          width;
        logic [SIZE_BITS-1:0]          height;
    } geom_cfg_t;

    // Mapper result toward the sequencer
    typedef struct packed {
        logic                  done;
        logic                  in_grid;
        logic [ADDR_BITS-1:0]  addr;
    } map_res_t;

endpackage

// ===== hdl/pdh_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module pdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pdh_map.sv =====
`timescale 1ns / 1ps
// Four-stage coordinate mapper: offset, Q8.24 scale, grid check, flipped row-major address.
module pdh_map import pdh_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_BITS-1:0]  raw_x,
    input  logic signed [COORD_BITS-1:0]  raw_y,
    input  geom_cfg_t                     geom,
    output map_res_t                      res
);

    // Stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1: offset from origin, 33-bit so the sign is exact
    logic [COORD_BITS:0]   dx_full, dy_full;
    logic                  xneg1_reg, yneg1_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;

    // Stage 2: scale
    logic                  xneg2_reg, yneg2_reg;
    logic [PROD_BITS-1:0]  xprod_reg, yprod_reg;

    // Stage 3: grid check
    logic [PIX_BITS-1:0]   xp, yp;
    logic                  xin, yin;
    logic                  in3_reg;
    logic [SIZE_BITS-1:0]  px_reg, py_reg;

    // Stage 4: address
    logic [SIZE_BITS-1:0]   row;
    logic [2*SIZE_BITS-1:0] lin;
    logic                   in4_reg;
    logic [ADDR_BITS-1:0]   addr4_reg;

    assign dx_full = {raw_x[COORD_BITS-1], raw_x} - {geom.x_origin[COORD_BITS-1], geom.x_origin};
    assign dy_full = {raw_y[COORD_BITS-1], raw_y} - {geom.y_origin[COORD_BITS-1], geom.y_origin};

    assign xp  = xprod_reg[PROD_BITS-1:FRAC_BITS];
    assign yp  = yprod_reg[PROD_BITS-1:FRAC_BITS];
    assign xin = !xneg2_reg && (xp < PIX_BITS'(geom.width));
    assign yin = !yneg2_reg && (yp < PIX_BITS'(geom.height));

    // py < height, so the flipped row never wraps
    assign row = geom.height - SIZE_BITS'(1) - py_reg;
    assign lin = row * geom.width + (2*SIZE_BITS)'(px_reg);

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        xneg1_reg <= dx_full[COORD_BITS];
        yneg1_reg <= dy_full[COORD_BITS];
        dx_reg    <= dx_full[COORD_BITS-1:0];
        dy_reg    <= dy_full[COORD_BITS-1:0];

        xneg2_reg <= xneg1_reg;
        yneg2_reg <= yneg1_reg;
        xprod_reg <= dx_reg * geom.x_gain;
        yprod_reg <= dy_reg * geom.y_gain;

        in3_reg <= xin && yin;
        px_reg  <= xp[SIZE_BITS-1:0];
        py_reg  <= yp[SIZE_BITS-1:0];

        in4_reg   <= in3_reg;
        addr4_reg <= lin[ADDR_BITS-1:0];
    end

    assign res = '{done: v4_reg, in_grid: in4_reg, addr: addr4_reg};

endmodule

// ===== hdl/point_density_histogram_top.sv =====
`timescale 1ns / 1ps
// Point density histogram: strided point binning into a count store with read-and-clear.
// Kept point: the word passes the four-stage mapper and one read of the count memory, then its result
//   is registered once the output is free; no new word is taken until that result has been loaded.
// Skipped point, read, frame or unknown request: result registered in S_DONE once the output is free.
// Reset: registers to defaults, then a pass over all 65536 store words zeroes the store; no request is taken
//   during the pass, configuration writes are.
module point_density_histogram_top import pdh_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  req_word_t                req_word,
    output logic                     res_valid,
    input  logic                     res_ready,
    output res_word_t                res_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_DONE
    } state_t;

    // Configuration registers
    logic [SIZE_BITS-1:0]          width_reg, height_reg;
    logic signed [COORD_BITS-1:0]  x_origin_reg, y_origin_reg;
    logic [GAIN_BITS-1:0]          x_gain_reg, y_gain_reg;
    logic [STRIDE_BITS-1:0]        stride_reg;

    // Sequencer and frame state
    state_t                  state_reg;
    logic                    op_hit_reg, op_read_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic [STRIDE_BITS-1:0]  phase_reg;
    logic [STAT_BITS-1:0]    kept_reg;
    logic [COUNT_BITS-1:0]   max_reg;
    logic                    res_valid_reg;
    res_word_t               res_reg;

    // Store clearing pass
    logic                  clr_busy_reg;
    logic [ADDR_BITS-1:0]  clr_addr_reg;

    geom_cfg_t               geom;
    map_res_t                map_res;
    logic                    accept, map_start, keep, read_in_range, out_free, finish;
    logic [STRIDE_BITS-1:0]  stride_eff, phase_next;
    logic [STRIDE_BITS:0]    phase_inc;
    logic                    ram_we, ram_re;
    logic [ADDR_BITS-1:0]    ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0]   ram_wdata, ram_rdata, bumped, max_next;

    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                        input int hi);
        logic [SIZE_BITS-1:0] r;
        if (v == '0)
        begin
            r = SIZE_BITS'(1);
        end
        else if (int'(v) > hi)
        begin
            r = SIZE_BITS'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SIZE_BITS'(256);
            height_reg   <= SIZE_BITS'(256);
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            x_gain_reg   <= '0;
            y_gain_reg   <= '0;
            stride_reg   <= STRIDE_BITS'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg    <= cfg_data[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT:  height_reg   <= cfg_data[SIZE_BITS-1:0];
                REG_X_ORIGIN_RAW:  x_origin_reg <= cfg_data[COORD_BITS-1:0];
                REG_Y_ORIGIN_RAW:  y_origin_reg <= cfg_data[COORD_BITS-1:0];
                REG_X_GAIN:        x_gain_reg   <= cfg_data[GAIN_BITS-1:0];
                REG_Y_GAIN:        y_gain_reg   <= cfg_data[GAIN_BITS-1:0];
                REG_SAMPLE_STRIDE: stride_reg   <= cfg_data[STRIDE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    assign geom = '{x_origin: x_origin_reg, y_origin: y_origin_reg,
                    x_gain: x_gain_reg, y_gain: y_gain_reg,
                    width: clamp_size(width_reg, MAX_WIDTH),
                    height: clamp_size(height_reg, MAX_HEIGHT)};

    // Handshake and sampling phase
    assign req_ready  = (state_reg == S_IDLE) && !clr_busy_reg;
    assign accept     = req_valid && req_ready;
    assign keep       = (phase_reg == '0);
    assign stride_eff = (stride_reg == '0) ? STRIDE_BITS'(1) : stride_reg;
    assign phase_inc  = {1'b0, phase_reg} + (STRIDE_BITS+1)'(1);
    assign phase_next = (phase_inc >= {1'b0, stride_eff}) ? '0 : phase_inc[STRIDE_BITS-1:0];
    assign map_start  = accept && (req_word.req_type == REQ_POINT) && keep;
    assign read_in_range = int'(req_word.pixel_index) < STORE_DEPTH;

    pdh_map u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .start (map_start),
        .raw_x (req_word.raw_x),
        .raw_y (req_word.raw_y),
        .geom  (geom),
        .res   (map_res)
    );

    // Count memory port control
    assign out_free  = !res_valid_reg || res_ready;
    assign finish    = (state_reg == S_DONE) && out_free;
    assign ram_re    = (accept && (req_word.req_type == REQ_READ) && read_in_range) ||
                       ((state_reg == S_MAP) && map_res.done && map_res.in_grid);
    assign ram_raddr = (state_reg == S_IDLE) ? req_word.pixel_index[ADDR_BITS-1:0]
                                             : map_res.addr;
    assign bumped    = (ram_rdata == COUNT_LIMIT) ? ram_rdata
                                                  : ram_rdata + COUNT_BITS'(1);
    assign max_next  = (op_hit_reg && (bumped > max_reg)) ? bumped : max_reg;
    assign ram_we    = clr_busy_reg || (finish && (op_hit_reg || op_read_reg));
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : addr_reg;
    assign ram_wdata = (!clr_busy_reg && op_hit_reg) ? bumped : '0;

    pdh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
            if (clr_addr_reg == ADDR_BITS'(STORE_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Sequencer, frame statistics and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_hit_reg    <= 1'b0;
            op_read_reg   <= 1'b0;
            addr_reg      <= '0;
            phase_reg     <= '0;
            kept_reg      <= '0;
            max_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            // a new result in the same cycle keeps valid high
            if (res_valid_reg && res_ready && !finish)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_hit_reg  <= 1'b0;
                        op_read_reg <= 1'b0;
                        addr_reg    <= req_word.pixel_index[ADDR_BITS-1:0];
                        state_reg   <= map_start ? S_MAP : S_DONE;
                        unique case (req_word.req_type)
                            REQ_POINT:
                            begin
                                phase_reg <= phase_next;
                                if (keep)
                                begin
                                    if (kept_reg != STAT_LIMIT)
                                    begin
                                        kept_reg <= kept_reg + STAT_BITS'(1);
                                    end
                                end
                            end
                            REQ_READ:
                            begin
                                op_read_reg <= read_in_range;
                            end
                            REQ_FRAME:
                            begin
                                max_reg   <= '0;
                                kept_reg  <= '0;
                                phase_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAP:
                begin
                    if (map_res.done)
                    begin
                        op_hit_reg <= map_res.in_grid;
                        addr_reg   <= map_res.addr;
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        max_reg               <= max_next;
                        res_valid_reg         <= 1'b1;
                        res_reg.hit           <= op_hit_reg;
                        res_reg.hit_index     <= op_hit_reg ? INDEX_BITS'(addr_reg) : '0;
                        res_reg.density       <= op_hit_reg  ? STAT_BITS'(bumped) :
                                                 op_read_reg ? STAT_BITS'(ram_rdata) : '0;
                        res_reg.max_density   <= STAT_BITS'(max_next);
                        res_reg.points_read   <= kept_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

    // Checks
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !req_ready)
        else $error("request taken during store clearing pass");

    a_single_port_use: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("count store read and written in the same cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready)
        else $error("second word taken before the first one finished");

    a_max_covers_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.hit) |-> (res_word.density <= res_word.max_density))
        else $error("hit count exceeds reported maximum");

endmodule

// ===== sim/tb_point_density_histogram_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the point density histogram: directed and random words vs. a predictor.
module tb_point_density_histogram_top;
    import pdh_pkg::*;

    localparam int          IDLE_PCT      = 31;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 400;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam logic [31:0] ONE_PER_UNIT  = 32'h0100_0000;
    localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    req_word_t                req_word  = '0;
    logic                     res_valid;
    logic                     res_ready = 1'b0;
    res_word_t                res_word;

    point_density_histogram_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    always #10 clk = ~clk;

    // Stimulus and expectation stores
    req_word_t request_backlog[$];
    res_word_t density_reports[$];

    int  errors    = 0;
    int  cycles    = 0;
    int  hold_left = 0;
    bit  calm      = 1'b0;
    bit  squeeze   = 1'b0;
    bit  squeezed  = 1'b0;
    int unsigned x_reach = 0;
    int unsigned y_reach = 0;

    // Predictor copy of the registers
    logic [SIZE_BITS-1:0]          cfg_width    = 9'd256;
    logic [SIZE_BITS-1:0]          cfg_height   = 9'd256;
    logic signed [COORD_BITS-1:0]  cfg_x_origin = '0;
    logic signed [COORD_BITS-1:0]  cfg_y_origin = '0;
    logic [GAIN_BITS-1:0]          cfg_x_gain   = '0;
    logic [GAIN_BITS-1:0]          cfg_y_gain   = '0;
    logic [STRIDE_BITS-1:0]        cfg_stride   = 16'd1;

    // Predictor copy of the histogram state
    bit [COUNT_BITS-1:0]  bin_counts [STORE_DEPTH];
    logic [STAT_BITS-1:0] peak_count   = '0;
    logic [STAT_BITS-1:0] kept_points  = '0;
    logic [15:0]          stride_phase = '0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Zero acts as one, oversize acts as the maximum
    function automatic int unsigned effective_size(input logic [SIZE_BITS-1:0] v,
                                                   input int unsigned hi);
        if (v == 0)
            return 1;
        return (32'(v) > hi) ? hi : 32'(v);
    endfunction

    // Raw coordinate to pixel; fails below origin or at/after the limit
    function automatic bit locate(input logic signed [31:0] raw, input logic signed [31:0] origin,
                                  input logic [31:0] gain, input int unsigned limit,
                                  output int unsigned pix);
        longint      offset;
        logic [63:0] span_u;
        logic [63:0] scaled;
        pix    = 0;
        offset = longint'(raw) - longint'(origin);
        if (offset < 0)
            return 1'b0;
        span_u = offset;
        scaled = (span_u * {32'd0, gain}) >> FRAC_BITS;
        if (scaled >= 64'(limit))
            return 1'b0;
        pix = scaled[31:0];
        return 1'b1;
    endfunction

    // Apply one accepted request word to the predicted state, queue its result
    task automatic bin_request(input req_word_t w);
        res_word_t   r;
        int unsigned step_len, cols, rows, px, py, addr;
        bit          keep, in_x, in_y;
        r = '0;
        case (w.req_type)
            REQ_POINT:
            begin
                step_len = (cfg_stride == 0) ? 1 : 32'(cfg_stride);
                keep     = (stride_phase == 0);
                if (32'(stride_phase) + 1 >= step_len)
                    stride_phase = '0;
                else
                    stride_phase = stride_phase + 16'd1;
                if (keep)
                begin
                    if (kept_points != STAT_LIMIT)
                        kept_points = kept_points + 32'd1;
                    cols = effective_size(cfg_width, MAX_WIDTH);
                    rows = effective_size(cfg_height, MAX_HEIGHT);
                    in_x = locate(w.raw_x, cfg_x_origin, cfg_x_gain, cols, px);
                    in_y = locate(w.raw_y, cfg_y_origin, cfg_y_gain, rows, py);
                    if (in_x && in_y)
                    begin
                        // rows are flipped: bottom row lands at the end of the store
                        addr = (rows - 1 - py) * cols + px;
                        if (bin_counts[addr] != COUNT_LIMIT)
                            bin_counts[addr] = bin_counts[addr] + 32'd1;
                        if (bin_counts[addr] > peak_count)
                            peak_count = bin_counts[addr];
                        r.hit       = 1'b1;
                        r.hit_index = addr[INDEX_BITS-1:0];
                        r.density   = bin_counts[addr];
                    end
                end
            end
            REQ_READ:
            begin
                if (w.pixel_index < STORE_DEPTH)
                begin
                    r.density                 = bin_counts[w.pixel_index];
                    bin_counts[w.pixel_index] = '0;
                end
            end
            REQ_FRAME:
            begin
                peak_count   = '0;
                kept_points  = '0;
                stride_phase = '0;
            end
            default: ;
        endcase
        r.max_density = peak_count;
        r.points_read = kept_points;
        density_reports.push_back(r);
    endtask

    function automatic req_word_t make_req(input logic [1:0] kind, input logic [31:0] x,
                                           input logic [31:0] y, input logic [15:0] idx);
        req_word_t w;
        w.req_type    = kind;
        w.raw_x       = x;
        w.raw_y       = y;
        w.pixel_index = idx;
        return w;
    endfunction

    // Mostly points aimed around the grid, plus reads, frames, unknown codes and noise
    function automatic req_word_t random_request();
        req_word_t   w;
        int unsigned roll, cols, rows;
        logic [31:0] nudge;
        w.req_type    = REQ_POINT;
        w.raw_x       = $urandom;
        w.raw_y       = $urandom;
        w.pixel_index = INDEX_BITS'($urandom);
        roll = $urandom_range(99);
        cols = effective_size(cfg_width, MAX_WIDTH);
        rows = effective_size(cfg_height, MAX_HEIGHT);
        if (roll < 70)
        begin
            if ($urandom_range(9) != 0)
            begin
                nudge   = ($urandom_range(9) == 0) ? 32'd3 : 32'd0;
                w.raw_x = cfg_x_origin + $urandom_range(x_reach) - nudge;
                nudge   = ($urandom_range(9) == 0) ? 32'd3 : 32'd0;
                w.raw_y = cfg_y_origin + $urandom_range(y_reach) - nudge;
            end
        end
        else if (roll < 86)
        begin
            w.req_type = REQ_READ;
            if ($urandom_range(3) != 0)
                w.pixel_index = INDEX_BITS'($urandom_range(cols * rows - 1));
        end
        else if (roll < 91)
        begin
            w.req_type = REQ_FRAME;
        end
        else if (roll < 95)
        begin
            w.req_type = REQ_UNKNOWN;
        end
        return w;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width    = value[SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT:  cfg_height   = value[SIZE_BITS-1:0];
            REG_X_ORIGIN_RAW:  cfg_x_origin = value;
            REG_Y_ORIGIN_RAW:  cfg_y_origin = value;
            REG_X_GAIN:        cfg_x_gain   = value;
            REG_Y_GAIN:        cfg_y_gain   = value;
            REG_SAMPLE_STRIDE: cfg_stride   = value[STRIDE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [8:0] width, input logic [8:0] height,
                             input logic [31:0] x0, input logic [31:0] y0,
                             input logic [31:0] xg, input logic [31:0] yg,
                             input logic [15:0] stride);
        write_reg(REG_IMAGE_WIDTH, 32'(width));
        write_reg(REG_IMAGE_HEIGHT, 32'(height));
        write_reg(REG_X_ORIGIN_RAW, x0);
        write_reg(REG_Y_ORIGIN_RAW, y0);
        write_reg(REG_X_GAIN, xg);
        write_reg(REG_Y_GAIN, yg);
        write_reg(REG_SAMPLE_STRIDE, 32'(stride));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait until every word is accepted and answered, then let the pipe settle
    task automatic drain();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req_valid || density_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int unsigned count, input int unsigned xr,
                                input int unsigned yr);
        @(negedge clk);
        x_reach = xr;
        y_reach = yr;
        repeat (count) request_backlog.push_back(random_request());
        drain();
    endtask

    // Request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                bin_request(req_word);
            if (!req_valid || req_ready)
            begin
                if (request_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    req_valid <= 1'b1;
                    req_word  <= request_backlog.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, so the block backs up into its input
    always @(posedge clk)
    begin
        if (squeeze && !squeezed)
        begin
            hold_left <= LONG_HOLD;
            squeezed  <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : monitor
        res_word_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (density_reports.size() == 0)
                begin
                    report_mismatch("result word with no request outstanding");
                end
                else
                begin
                    want = density_reports.pop_front();
                    check_field("hit", 32'(res_word.hit), 32'(want.hit));
                    check_field("hit_index", 32'(res_word.hit_index), 32'(want.hit_index));
                    check_field("density", res_word.density, want.density);
                    check_field("max_density", res_word.max_density, want.max_density);
                    check_field("points_read", res_word.points_read, want.points_read);
                end
            end
            res_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: zero gain maps every non-negative point to the bottom-left pixel
        @(negedge clk);
        request_backlog.push_back(make_req(REQ_POINT, 32'd0, 32'd0, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, -32'sd1, 32'd5, 16'd0));
        request_backlog.push_back(make_req(REQ_READ, 32'd0, 32'd0, 16'hFF00));
        drain();

        // Small grid: corners, edges, drops below origin and past the last column/row
        configure(9'd16, 9'd8, -32'sd100, 32'd50, ONE_PER_UNIT, ONE_PER_UNIT >> 1, 16'd1);
        @(negedge clk);
        request_backlog.push_back(make_req(REQ_POINT, -32'sd100, 32'd50, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, -32'sd100, 32'd50, 16'hFFFF));
        request_backlog.push_back(make_req(REQ_POINT, -32'sd85, 32'd65, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, -32'sd84, 32'd50, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, -32'sd100, 32'd66, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, -32'sd101, 32'd50, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0));
        request_backlog.push_back(make_req(REQ_READ, 32'd0, 32'd0, 16'd112));
        request_backlog.push_back(make_req(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        request_backlog.push_back(make_req(REQ_READ, 32'd0, 32'd0, 16'd0));
        request_backlog.push_back(make_req(REQ_UNKNOWN, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 16'hBEEF));
        request_backlog.push_back(make_req(REQ_FRAME, 32'd0, 32'd0, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, -32'sd90, 32'd53, 16'd0));
        drain();

        // Stride of three: keep, skip, skip, keep; a frame restarts the phase
        configure(9'd16, 9'd8, -32'sd100, 32'd50, ONE_PER_UNIT, ONE_PER_UNIT >> 1, 16'd3);
        @(negedge clk);
        repeat (4) request_backlog.push_back(make_req(REQ_POINT, -32'sd100, 32'd50, 16'd0));
        request_backlog.push_back(make_req(REQ_FRAME, 32'd0, 32'd0, 16'd0));
        request_backlog.push_back(make_req(REQ_POINT, -32'sd99, 32'd51, 16'd0));
        drain();

        // Full grid, four raw units per pixel, with the long receiver hold-off
        configure(9'd256, 9'd256, -32'sd1000, 32'd2000, ONE_PER_UNIT >> 2, ONE_PER_UNIT >> 2,
                  16'd2);
        @(negedge clk);
        squeeze = 1'b1;
        queue_random(220, 1032, 1032);

        // Single-pixel grid
        configure(9'd1, 9'd1, 32'd0, 32'd0, ONE_PER_UNIT, ONE_PER_UNIT, 16'd2);
        queue_random(60, 3, 3);

        // Zero width, oversize height, zero stride, origin near the top of the range
        configure(9'd0, 9'd511, 32'h7FFF_FF00, -32'sd5, ONE_PER_UNIT, ONE_PER_UNIT << 2, 16'd0);
        queue_random(80, 3, 70);

        // Extreme origins and gains, oversize width
        configure(9'd300, 9'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  16'd1);
        queue_random(60, 2, 2);

        // Dense small grid with no idling on either side
        configure(9'd32, 9'd32, 32'd0, 32'd0, ONE_PER_UNIT, ONE_PER_UNIT, 16'd1);
        @(negedge clk);
        calm = 1'b1;
        queue_random(150, 33, 33);
        calm = 1'b0;

        // Largest stride
        configure(9'd64, 9'd64, -32'sd7, -32'sd7, ONE_PER_UNIT, ONE_PER_UNIT, 16'hFFFF);
        queue_random(30, 65, 65);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
